// File: design/clsr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clsr_pkg: shared types and constants of the combined LCG shuffle generator
// Generator constants, reciprocals for constant division, table geometry,
// sequencer states and the request/response structs of the Schrage unit.
// ----------------------------------------------------------------------------
package clsr_pkg;

    localparam int TABLE_SIZE   = 32;
    localparam int WARMUP_STEPS = 8;
    localparam int STEP_TOTAL   = TABLE_SIZE + WARMUP_STEPS;

    localparam int VAL_W  = 31;
    localparam int IDX_W  = $clog2(TABLE_SIZE);
    localparam int STEP_W = $clog2(STEP_TOTAL + 1);
    localparam int K_W    = 16;   // quotient and remainder of a Schrage split
    localparam int R_W    = 14;

    // floor(x / q) is taken as (x * RECIP) >> RECIP_SHIFT, low by at most one
    localparam int RECIP_W     = 32;
    localparam int RECIP_SHIFT = 47;
    localparam int PROD_W      = VAL_W + RECIP_W;

    localparam logic [VAL_W-1:0] IM1        = 31'd2147483563;
    localparam logic [VAL_W-1:0] IM2        = 31'd2147483399;
    localparam logic [VAL_W-1:0] IMM1       = 31'd2147483562;
    localparam logic [VAL_W-1:0] SEED2_INIT = 31'd123456789;

    localparam logic [K_W-1:0] IA1 = 16'd40014;
    localparam logic [K_W-1:0] IQ1 = 16'd53668;
    localparam logic [R_W-1:0] IR1 = 14'd12211;
    localparam logic [K_W-1:0] IA2 = 16'd40692;
    localparam logic [K_W-1:0] IQ2 = 16'd52774;
    localparam logic [R_W-1:0] IR2 = 14'd3791;

    localparam longint unsigned RECIP_ONE = 64'd1 << RECIP_SHIFT;
    localparam logic [RECIP_W-1:0] RECIP1 = RECIP_W'(RECIP_ONE / 64'(IQ1));
    localparam logic [RECIP_W-1:0] RECIP2 = RECIP_W'(RECIP_ONE / 64'(IQ2));

    // table slot = last output / NDIV
    localparam longint unsigned NDIV_L = 64'd1 + 64'(IMM1) / 64'(TABLE_SIZE);
    localparam logic [VAL_W-1:0]   NDIV      = VAL_W'(NDIV_L);
    localparam logic [RECIP_W-1:0] IDX_RECIP = RECIP_W'(RECIP_ONE / NDIV_L);
    localparam int IDX_QW = $clog2(TABLE_SIZE + 2);
    localparam int BND_W  = IDX_QW + VAL_W;

    typedef enum logic {
        GEN_FIRST,
        GEN_SECOND
    } gen_sel_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WARM,
        ST_DRAW_G1,
        ST_DRAW_G2,
        ST_DRAW_WAIT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic             vld;
        gen_sel_t         sel;
        logic [VAL_W-1:0] z;
    } sch_req_t;

    typedef struct packed {
        logic             vld;
        gen_sel_t         sel;
        logic [VAL_W-1:0] value;
    } sch_rsp_t;

endpackage

// File: design/clsr_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clsr_req_if: request channel
// valid/ready channel carrying a draw or reseed request.
// ----------------------------------------------------------------------------
interface clsr_req_if import clsr_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             req_type;
    logic [VAL_W-1:0] seed_value;

    modport source (output valid, output req_type, output seed_value, input ready);
    modport sink   (input valid, input req_type, input seed_value, output ready);
endinterface

// File: design/clsr_draw_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clsr_draw_if: result channel
// valid/ready channel carrying one integer draw.
// ----------------------------------------------------------------------------
interface clsr_draw_if import clsr_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] draw;

    modport source (output valid, output draw, input ready);
    modport sink   (input valid, input draw, output ready);
endinterface

// File: design/combined_lcg_shuffle_rng.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// combined_lcg_shuffle_rng: combined prime-modulus LCG pair with table shuffle
// Draw/reseed requests in, one 31-bit integer draw out per request.
// ----------------------------------------------------------------------------
// Each request yields exactly one draw in 1..2147483562; divide it by
// 2147483563 for the uniform deviate. For a draw request both generators
// go through the shared five-stage Schrage pipeline, the second issued in
// the cycle after the first, and the last stage of the second generator
// sets the finish. A reseed feeds the result of every warm-up step
// straight back into the same pipeline, followed by a normal draw.
// The shuffle table sits in a 32-entry synchronous memory with per-entry
// valid flops, so after reset it reads as zeros without a clearing pass.
// One request is in flight at a time; a new request is taken while a
// finished draw still waits in the output register.
// ----------------------------------------------------------------------------
module combined_lcg_shuffle_rng import clsr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    clsr_req_if.sink    req,
    clsr_draw_if.source rsp
);

    state_t state_reg;
    state_t state_next;

    logic [VAL_W-1:0] g1_reg;
    logic [VAL_W-1:0] g1_next;
    logic [VAL_W-1:0] g2_reg;
    logic [VAL_W-1:0] g2_next;
    logic [VAL_W-1:0] last_reg;
    logic [VAL_W-1:0] last_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic [TABLE_SIZE-1:0] valid_reg;
    logic [TABLE_SIZE-1:0] valid_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [VAL_W-1:0] out_draw_reg;
    logic [VAL_W-1:0] out_draw_next;
    logic             req_ready;

    sch_req_t sch_op;
    sch_rsp_t sch_res;

    // shuffle table memory
    logic [VAL_W-1:0] shuf_mem [TABLE_SIZE];
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [VAL_W-1:0] wr_data;
    logic [VAL_W-1:0] rd_data_reg;
    logic             entry_vld_reg;
    logic [VAL_W-1:0] entry;

    // slot index pipeline (free running on last_reg)
    logic [PROD_W-1:0] i1_prod;
    logic [IDX_QW-1:0] i1_q_next;
    logic [IDX_QW-1:0] i1_q_reg;
    logic [VAL_W-1:0]  i1_lo_reg;
    logic [BND_W-1:0]  i2_bnd_next;
    logic [BND_W-1:0]  i2_bnd_reg;
    logic [IDX_QW-1:0] i2_q_reg;
    logic [VAL_W-1:0]  i2_lo_reg;
    logic [IDX_QW-1:0] i3_q;
    logic [IDX_W-1:0]  idx_next;
    logic [IDX_W-1:0]  idx_reg;

    logic signed [31:0] y_diff;
    logic [VAL_W-1:0]   y_value;

    clsr_schrage u_schrage
    (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (sch_op),
        .res   (sch_res)
    );

    // slot = floor(last / NDIV): reciprocal estimate, then one upward fix
    always_comb
    begin
        i1_prod     = PROD_W'(last_reg) * PROD_W'(IDX_RECIP);
        i1_q_next   = IDX_QW'(i1_prod >> RECIP_SHIFT);
        i2_bnd_next = BND_W'(i1_q_reg + 1'b1) * BND_W'(NDIV);
        i3_q        = (BND_W'(i2_lo_reg) >= i2_bnd_reg) ? (i2_q_reg + 1'b1) : i2_q_reg;
        if (i3_q >= IDX_QW'(TABLE_SIZE))
        begin
            idx_next = IDX_W'(TABLE_SIZE - 1);
        end
        else
        begin
            idx_next = i3_q[IDX_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        i1_q_reg   <= i1_q_next;
        i1_lo_reg  <= last_reg;
        i2_bnd_reg <= i2_bnd_next;
        i2_q_reg   <= i1_q_reg;
        i2_lo_reg  <= i1_lo_reg;
        idx_reg    <= idx_next;
    end

    // memory: one write port, one registered read at the current slot
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            shuf_mem[wr_addr] <= wr_data;
        end
        rd_data_reg   <= shuf_mem[idx_reg];
        entry_vld_reg <= valid_reg[idx_reg];
    end

    // never-written entries read as zero
    assign entry = entry_vld_reg ? rd_data_reg : '0;

    // combine picked entry with the new second generator
    always_comb
    begin
        y_diff = $signed({1'b0, entry}) - $signed({1'b0, sch_res.value});
        if (y_diff < 32'sd1)
        begin
            y_diff = y_diff + $signed({1'b0, IMM1});
        end
        y_value = y_diff[VAL_W-1:0];
    end

    always_comb
    begin
        logic [VAL_W-1:0] seed;
        logic [IDX_W-1:0] step_addr;

        seed      = (req.seed_value == '0) ? VAL_W'(1) : req.seed_value;
        step_addr = IDX_W'(step_reg - 1'b1);

        state_next     = state_reg;
        g1_next        = g1_reg;
        g2_next        = g2_reg;
        last_next      = last_reg;
        step_next      = step_reg;
        valid_next     = valid_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_draw_next  = out_draw_reg;
        req_ready      = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = idx_reg;
        wr_data        = g1_reg;
        sch_op.vld     = 1'b0;
        sch_op.sel     = GEN_FIRST;
        sch_op.z       = g1_reg;

        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req.valid)
                begin
                    sch_op.vld = 1'b1;
                    if (req.req_type)
                    begin
                        // load both generators, start the warm-up chain
                        g1_next    = seed;
                        g2_next    = seed;
                        step_next  = STEP_W'(STEP_TOTAL);
                        sch_op.z   = seed;
                        state_next = ST_WARM;
                    end
                    else
                    begin
                        state_next = ST_DRAW_G2;
                    end
                end
            end

            ST_WARM:
            begin
                if (sch_res.vld)
                begin
                    g1_next = sch_res.value;
                    // the last TABLE_SIZE steps fill the table from the top down
                    if (step_reg <= STEP_W'(TABLE_SIZE))
                    begin
                        wr_en                 = 1'b1;
                        wr_addr               = step_addr;
                        wr_data               = sch_res.value;
                        valid_next[step_addr] = 1'b1;
                    end
                    if (step_reg == STEP_W'(1))
                    begin
                        // slot 0 holds the final value: it is the new last output
                        last_next  = sch_res.value;
                        state_next = ST_DRAW_G1;
                    end
                    else
                    begin
                        sch_op.vld = 1'b1;
                        sch_op.z   = sch_res.value;
                        step_next  = step_reg - 1'b1;
                    end
                end
            end

            ST_DRAW_G1:
            begin
                sch_op.vld = 1'b1;
                state_next = ST_DRAW_G2;
            end

            ST_DRAW_G2:
            begin
                sch_op.vld = 1'b1;
                sch_op.sel = GEN_SECOND;
                sch_op.z   = g2_reg;
                state_next = ST_DRAW_WAIT;
            end

            ST_DRAW_WAIT:
            begin
                if (sch_res.vld)
                begin
                    if (sch_res.sel == GEN_FIRST)
                    begin
                        g1_next = sch_res.value;
                    end
                    else
                    begin
                        // refill the picked slot with the new first generator
                        g2_next             = sch_res.value;
                        last_next           = y_value;
                        wr_en               = 1'b1;
                        valid_next[idx_reg] = 1'b1;
                        if (!out_valid_reg || rsp.ready)
                        begin
                            out_valid_next = 1'b1;
                            out_draw_next  = y_value;
                            state_next     = ST_IDLE;
                        end
                        else
                        begin
                            state_next = ST_OUT;
                        end
                    end
                end
            end

            ST_OUT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_draw_next  = last_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            g1_reg        <= VAL_W'(1);
            g2_reg        <= SEED2_INIT;
            last_reg      <= '0;
            step_reg      <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            g1_reg        <= g1_next;
            g2_reg        <= g2_next;
            last_reg      <= last_next;
            step_reg      <= step_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_draw_reg <= out_draw_next;
    end

    assign req.ready = req_ready;
    assign rsp.valid = out_valid_reg;
    assign rsp.draw  = out_draw_reg;

endmodule

// File: design/clsr_schrage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clsr_schrage: pipelined Schrage step a*z mod m
// Five stages, one new operation per cycle, tagged with the generator.
// ----------------------------------------------------------------------------
module clsr_schrage import clsr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  sch_req_t op,
    output sch_rsp_t res
);

    logic [4:0] vld_reg;
    gen_sel_t   sel_reg [5];

    // stage 1: approximate quotient
    logic [PROD_W-1:0] s1_prod;
    logic [K_W-1:0]    s1_k_next;
    logic [K_W-1:0]    s1_k_reg;
    logic [VAL_W-1:0]  s1_z_reg;

    // stage 2: quotient times q
    logic [31:0]      s2_t_next;
    logic [31:0]      s2_t_reg;
    logic [K_W-1:0]   s2_k_reg;
    logic [VAL_W-1:0] s2_z_reg;

    // stage 3: remainder with one correction
    logic [31:0]    s3_diff;
    logic [K_W:0]   s3_rem_wide;
    logic [K_W-1:0] s3_q;
    logic [K_W-1:0] s3_rem_next;
    logic [K_W-1:0] s3_k_next;
    logic [K_W-1:0] s3_rem_reg;
    logic [K_W-1:0] s3_k_reg;

    // stage 4: the two products
    logic [31:0] s4_pa_next;
    logic [31:0] s4_pr_next;
    logic [31:0] s4_pa_reg;
    logic [31:0] s4_pr_reg;

    // stage 5: difference, wrap into range
    logic signed [32:0] s5_v;
    logic [VAL_W-1:0]   s5_value_next;
    logic [VAL_W-1:0]   s5_value_reg;

    always_comb
    begin
        s1_prod   = PROD_W'(op.z) * PROD_W'((op.sel == GEN_FIRST) ? RECIP1 : RECIP2);
        s1_k_next = K_W'(s1_prod >> RECIP_SHIFT);

        s2_t_next = 32'(s1_k_reg) * 32'((sel_reg[0] == GEN_FIRST) ? IQ1 : IQ2);

        s3_q        = (sel_reg[1] == GEN_FIRST) ? IQ1 : IQ2;
        s3_diff     = 32'(s2_z_reg) - s2_t_reg;
        s3_rem_wide = s3_diff[K_W:0];
        if (s3_rem_wide >= (K_W+1)'(s3_q))
        begin
            s3_rem_next = K_W'(s3_rem_wide - (K_W+1)'(s3_q));
            s3_k_next   = s2_k_reg + 1'b1;
        end
        else
        begin
            s3_rem_next = s3_rem_wide[K_W-1:0];
            s3_k_next   = s2_k_reg;
        end

        s4_pa_next = 32'(s3_rem_reg) * 32'((sel_reg[2] == GEN_FIRST) ? IA1 : IA2);
        s4_pr_next = 32'(s3_k_reg) * 32'((sel_reg[2] == GEN_FIRST) ? IR1 : IR2);

        s5_v = $signed({1'b0, s4_pa_reg}) - $signed({1'b0, s4_pr_reg});
        if (s5_v[32])
        begin
            s5_v = s5_v + $signed({2'b00, ((sel_reg[3] == GEN_FIRST) ? IM1 : IM2)});
        end
        s5_value_next = s5_v[VAL_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[3:0], op.vld};
        end
    end

    always_ff @(posedge clk)
    begin
        sel_reg[0]   <= op.sel;
        sel_reg[1]   <= sel_reg[0];
        sel_reg[2]   <= sel_reg[1];
        sel_reg[3]   <= sel_reg[2];
        sel_reg[4]   <= sel_reg[3];
        s1_k_reg     <= s1_k_next;
        s1_z_reg     <= op.z;
        s2_t_reg     <= s2_t_next;
        s2_k_reg     <= s1_k_reg;
        s2_z_reg     <= s1_z_reg;
        s3_rem_reg   <= s3_rem_next;
        s3_k_reg     <= s3_k_next;
        s4_pa_reg    <= s4_pa_next;
        s4_pr_reg    <= s4_pr_next;
        s5_value_reg <= s5_value_next;
    end

    assign res.vld   = vld_reg[4];
    assign res.sel   = sel_reg[4];
    assign res.value = s5_value_reg;

endmodule
